// ===== rtl/rir_pkg.sv =====
// Package with the shared constants, types and helpers of the frame rotator.
`default_nettype none

package rir_pkg;

  // Frame store geometry.
  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COORD_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SIZE_W      = $clog2(MAX_DIM + 1);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // Fixed field widths of the interface.
  localparam int PIXEL_W    = 32;
  localparam int DEST_W     = 9;
  localparam int CFG_SIZE_W = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH      = 3'd0,
    REG_SOURCE_HEIGHT     = 3'd1,
    REG_QUARTER_TURNS     = 3'd2,
    REG_MIRROR_HORIZONTAL = 3'd3,
    REG_MIRROR_VERTICAL   = 3'd4
  } cfg_reg_t;

  // Rotation codes.
  localparam logic [1:0] TURN_NONE = 2'd0;
  localparam logic [1:0] TURN_90   = 2'd1;
  localparam logic [1:0] TURN_180  = 2'd2;
  localparam logic [1:0] TURN_270  = 2'd3;

  // Effective geometry after clamping the size registers.
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [1:0]        quarter_turns;
    logic              mirror_h;
    logic              mirror_v;
  } geom_t;

  // Destination position and marks that travel with a fetch.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               row_end;
    logic               frame_end;
  } fetch_tag_t;

  // A size of zero acts as one, a size above the maximum acts as the maximum.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] v,
                                                   input int unsigned maxv);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (32'(v) > maxv) begin
      res = SIZE_W'(maxv);
    end else begin
      res = SIZE_W'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rir_frame_store.sv =====
// Frame store: one write port for loads, one registered read port for fetches.
`default_nettype none

module rir_frame_store
  import rir_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [PIXEL_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [PIXEL_W-1:0] rd_data_r
);

  logic [PIXEL_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rir_addr_gen.sv =====
// Destination raster counters and mapping of a destination pixel to its store address.
`default_nettype none

module rir_addr_gen
  import rir_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire geom_t             geom,
  input  wire logic              step,
  output fetch_tag_t             tag_r,
  output logic      [ADDR_W-1:0] rd_addr
);

  logic [COORD_W-1:0] out_col_r, out_col_nxt;
  logic [COORD_W-1:0] out_row_r, out_row_nxt;
  logic [COORD_W-1:0] rx_r, ry_r;

  logic [SIZE_W-1:0] dw, dh, dw_m1, dh_m1;
  logic [SIZE_W-1:0] xs, ys, xs_p1, ys_p1;
  logic [SIZE_W-1:0] sx, sy, rx, ry;
  logic              outside;
  logic              row_end, frame_end;

  logic [COORD_W+SIZE_W-1:0] prod;
  logic [COORD_W+SIZE_W-1:0] sum;

  always_comb begin
    dw    = geom.quarter_turns[0] ? geom.height : geom.width;
    dh    = geom.quarter_turns[0] ? geom.width  : geom.height;
    dw_m1 = dw - SIZE_W'(1);
    dh_m1 = dh - SIZE_W'(1);

    // A position left outside the frame by a size change restarts the frame.
    outside = (SIZE_W'(out_col_r) >= dw) || (SIZE_W'(out_row_r) >= dh);
    xs      = outside ? '0 : SIZE_W'(out_col_r);
    ys      = outside ? '0 : SIZE_W'(out_row_r);

    // Undo mirroring, then undo rotation.
    sx = geom.mirror_h ? (dw_m1 - xs) : xs;
    sy = geom.mirror_v ? (dh_m1 - ys) : ys;

    case (geom.quarter_turns)
      TURN_90: begin
        rx = dh_m1 - sy;
        ry = sx;
      end
      TURN_180: begin
        rx = dw_m1 - sx;
        ry = dh_m1 - sy;
      end
      TURN_270: begin
        rx = sy;
        ry = dw_m1 - sx;
      end
      default: begin
        rx = sx;
        ry = sy;
      end
    endcase

    row_end   = (xs == dw_m1);
    frame_end = row_end && (ys == dh_m1);

    xs_p1 = xs + SIZE_W'(1);
    ys_p1 = ys + SIZE_W'(1);
    if (xs_p1 < dw) begin
      out_col_nxt = COORD_W'(xs_p1);
      out_row_nxt = COORD_W'(ys);
    end else begin
      out_col_nxt = '0;
      out_row_nxt = (ys_p1 < dh) ? COORD_W'(ys_p1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (step) begin
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tag_r.col       <= COORD_W'(xs);
      tag_r.row       <= COORD_W'(ys);
      tag_r.row_end   <= row_end;
      tag_r.frame_end <= frame_end;
      rx_r            <= COORD_W'(rx);
      ry_r            <= COORD_W'(ry);
    end
  end

  // Raster address in the source, using the current source width.
  always_comb begin
    prod    = (COORD_W+SIZE_W)'(ry_r) * (COORD_W+SIZE_W)'(geom.width);
    sum     = prod + (COORD_W+SIZE_W)'(rx_r);
    rd_addr = ADDR_W'(sum);
  end

endmodule

`default_nettype wire

// ===== rtl/image_rotate_flip_remap_unit.sv =====
// Top level of the frame rotator: configuration, handshakes, load counter and output register.
//
// Input channel (in_*): each transfer carries a request type and a pixel. A load
// (in_req_type low) writes in_pixel_in to the next raster position of the source
// frame; loads beyond width times height are dropped. A fetch (in_req_type high)
// produces one destination pixel in raster order, with its column, row and the
// row-end and frame-end marks; after the frame end the next fetch starts over.
// Output channel (out_*): one transfer per fetch, in order.
// Configuration port (cfg_*): a write lands at the edge where cfg_wr_en is high;
// it is meant for idle periods only.
// A load writes the store at the edge where it is accepted, and loads can follow each
// other in every cycle while no fetch is in flight and the output register is free or
// being emptied. A fetch computes its source position in its accept cycle and registers
// it, the address register then feeds the registered frame store read, and the returned
// pixel is captured in the output register. The next item is taken once that result is
// transferred, so no new item is taken while a fetch is in flight.
// Reset clears the load counter, the raster position and the pipeline, and sets
// the registers to a 512 by 512 source with no rotation or mirroring. The frame
// store is not cleared. A stalled receiver holds the result and in_ready stays low.
`default_nettype none

module image_rotate_flip_remap_unit
  import rir_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [PIXEL_W-1:0]    in_pixel_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [PIXEL_W-1:0]    out_pixel_out,
  output logic      [DEST_W-1:0]     out_dest_col,
  output logic      [DEST_W-1:0]     out_dest_row,
  output logic                       out_row_end,
  output logic                       out_frame_end,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers, as written.
  logic [CFG_SIZE_W-1:0] source_width_r;
  logic [CFG_SIZE_W-1:0] source_height_r;
  logic [1:0]            quarter_turns_r;
  logic                  mirror_h_r;
  logic                  mirror_v_r;

  geom_t                 geom;
  logic [2*SIZE_W-1:0]   area;

  logic [CNT_W-1:0]      load_count_r;
  logic                  load_room;

  logic                  in_xfer, load_xfer, fetch_xfer, wr_en;
  logic                  s1_v_r, s2_v_r, out_valid_r;

  fetch_tag_t            tag_r;
  logic [ADDR_W-1:0]     rd_addr;
  logic [PIXEL_W-1:0]    rd_data_r;

  logic [PIXEL_W-1:0]    out_pixel_r;
  logic [DEST_W-1:0]     out_col_r, out_row_r;
  logic                  out_row_end_r, out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_width_r  <= CFG_SIZE_W'(512);
      source_height_r <= CFG_SIZE_W'(512);
      quarter_turns_r <= TURN_NONE;
      mirror_h_r      <= 1'b0;
      mirror_v_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:      source_width_r  <= cfg_data[CFG_SIZE_W-1:0];
        REG_SOURCE_HEIGHT:     source_height_r <= cfg_data[CFG_SIZE_W-1:0];
        REG_QUARTER_TURNS:     quarter_turns_r <= cfg_data[1:0];
        REG_MIRROR_HORIZONTAL: mirror_h_r      <= cfg_data[0];
        REG_MIRROR_VERTICAL:   mirror_v_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The clamped sizes are what every later computation sees.
  always_comb begin
    geom.width         = clamp_size(source_width_r, MAX_WIDTH);
    geom.height        = clamp_size(source_height_r, MAX_HEIGHT);
    geom.quarter_turns = quarter_turns_r;
    geom.mirror_h      = mirror_h_r;
    geom.mirror_v      = mirror_v_r;
    area               = (2*SIZE_W)'(geom.width) * (2*SIZE_W)'(geom.height);
    load_room          = ((2*SIZE_W)'(load_count_r) < area);
  end

  // Only one fetch is in flight, and it is taken only when the output register
  // will be free by the time its data returns.
  assign in_ready   = !s1_v_r && !s2_v_r && (!out_valid_r || out_ready);
  assign in_xfer    = in_valid && in_ready;
  assign load_xfer  = in_xfer && !in_req_type;
  assign fetch_xfer = in_xfer && in_req_type;
  assign wr_en      = load_xfer && load_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
    end else if (wr_en) begin
      load_count_r <= load_count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= fetch_xfer;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  rir_addr_gen u_addr_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .step    (fetch_xfer),
    .tag_r   (tag_r),
    .rd_addr (rd_addr)
  );

  rir_frame_store u_frame_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (load_count_r[ADDR_W-1:0]),
    .wr_data   (in_pixel_in),
    .rd_en     (s1_v_r),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  // The returned pixel and its tag are captured together in the output register.
  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      out_pixel_r     <= rd_data_r;
      out_col_r       <= DEST_W'(tag_r.col);
      out_row_r       <= DEST_W'(tag_r.row);
      out_row_end_r   <= tag_r.row_end;
      out_frame_end_r <= tag_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_dest_col  = out_col_r;
  assign out_dest_row  = out_row_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!s1_v_r && !s2_v_r))
    else $error("input taken while a fetch is in flight");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("frame store read did not follow the address stage");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |=> out_valid_r)
    else $error("returned pixel did not reach the output register");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r || s2_v_r) |-> !out_valid_r)
    else $error("output register occupied while a fetch is in flight");
`endif

endmodule

`default_nettype wire

// ===== tb/frame_rotation_checker.sv =====
`timescale 1ns / 1ps
// Checker of the frame rotator: watches all three ports, predicts each fetch and compares.
module frame_rotation_checker
  import rir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [PIXEL_W-1:0]    in_pixel_in,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PIXEL_W-1:0]    out_pixel_out,
  input  logic [DEST_W-1:0]     out_dest_col,
  input  logic [DEST_W-1:0]     out_dest_row,
  input  logic                  out_row_end,
  input  logic                  out_frame_end,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    results_owed,
  output int                    mismatch_total
);

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [DEST_W-1:0]  col;
    logic [DEST_W-1:0]  row;
    logic               row_end;
    logic               frame_end;
  } dest_pixel_t;

  bit [PIXEL_W-1:0]      pixel_mem [STORE_DEPTH];
  int unsigned           pixels_loaded;
  int unsigned           next_col;
  int unsigned           next_row;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [1:0]            turns_reg;
  logic                  flip_cols;
  logic                  flip_rows;
  dest_pixel_t           expected_pixels [$];
  int                    failures;

  // Size registers: zero behaves as one, anything beyond the store behaves as the maximum.
  function automatic int unsigned effective_dim(input logic [CFG_DATA_W-1:0] raw,
                                                input int unsigned limit);
    int unsigned v;
    v = raw;
    if (v == 0) v = 1;
    if (v > limit) v = limit;
    return v;
  endfunction

  task automatic predict_transfer(input logic is_fetch, input logic [PIXEL_W-1:0] pix);
    int unsigned w, h, dw, dh, x, y, sx, sy, rx, ry;
    dest_pixel_t want;
    w  = effective_dim(width_reg, MAX_WIDTH);
    h  = effective_dim(height_reg, MAX_HEIGHT);
    dw = turns_reg[0] ? h : w;
    dh = turns_reg[0] ? w : h;
    if (!is_fetch) begin
      if (pixels_loaded < w * h) begin
        pixel_mem[pixels_loaded % STORE_DEPTH] = pix;
        pixels_loaded++;
      end
      return;
    end
    if (next_col >= dw || next_row >= dh) begin
      next_col = 0;
      next_row = 0;
    end
    x  = next_col;
    y  = next_row;
    sx = flip_cols ? dw - 1 - x : x;
    sy = flip_rows ? dh - 1 - y : y;
    case (turns_reg)
      TURN_90: begin
        rx = dh - 1 - sy;
        ry = sx;
      end
      TURN_180: begin
        rx = dw - 1 - sx;
        ry = dh - 1 - sy;
      end
      TURN_270: begin
        rx = sy;
        ry = dw - 1 - sx;
      end
      default: begin
        rx = sx;
        ry = sy;
      end
    endcase
    want.pixel     = pixel_mem[(ry * w + rx) % STORE_DEPTH];
    want.col       = DEST_W'(x);
    want.row       = DEST_W'(y);
    want.row_end   = (x == dw - 1);
    want.frame_end = (x == dw - 1) && (y == dh - 1);
    expected_pixels.push_back(want);
    if (x + 1 < dw) begin
      next_col = x + 1;
    end else begin
      next_col = 0;
      next_row = (y + 1 < dh) ? y + 1 : 0;
    end
  endtask

  task automatic check_result();
    dest_pixel_t got, want;
    got.pixel     = out_pixel_out;
    got.col       = out_dest_col;
    got.row       = out_dest_row;
    got.row_end   = out_row_end;
    got.frame_end = out_frame_end;
    if (expected_pixels.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("[%0t] result with nothing outstanding: pixel %h col %0d row %0d",
                 $realtime, got.pixel, got.col, got.row);
      return;
    end
    want = expected_pixels.pop_front();
    if (got !== want) begin
      failures++;
      if (failures <= 10)
        $display("[%0t] mismatch: expected pixel %h col %0d row %0d row_end %b frame_end %b,",
                 $realtime, want.pixel, want.col, want.row, want.row_end, want.frame_end,
                 " got pixel %h col %0d row %0d row_end %b frame_end %b",
                 got.pixel, got.col, got.row, got.row_end, got.frame_end);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pixels_loaded = 0;
      next_col      = 0;
      next_row      = 0;
      width_reg     = CFG_DATA_W'(MAX_WIDTH);
      height_reg    = CFG_DATA_W'(MAX_HEIGHT);
      turns_reg     = TURN_NONE;
      flip_cols     = 1'b0;
      flip_rows     = 1'b0;
      expected_pixels.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:      width_reg  = cfg_data;
          REG_SOURCE_HEIGHT:     height_reg = cfg_data;
          REG_QUARTER_TURNS:     turns_reg  = cfg_data[1:0];
          REG_MIRROR_HORIZONTAL: flip_cols  = cfg_data[0];
          REG_MIRROR_VERTICAL:   flip_rows  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_transfer(in_req_type, in_pixel_in);
      if (out_valid && out_ready) check_result();
    end
    results_owed   <= expected_pixels.size();
    mismatch_total <= failures;
  end

endmodule

// ===== tb/image_rotate_flip_remap_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench top of the frame rotator: stimulus, flow control on both channels and the verdict.
module image_rotate_flip_remap_unit_test
  import rir_pkg::*;
();

  // Request codes carried by in_req_type.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  localparam int ITEM_TARGET   = 1650;
  // No correct run goes this many cycles without a transfer: the longest sender gap, the
  // longest receiver stall, the pipeline and a full register update are far below it.
  localparam int IDLE_LIMIT    = 1000;
  // A fetch passes the address register, the store read register and the output register, and a
  // load only writes the store, so once the last result is out the block is surely quiet after this wait.
  localparam int SETTLE_CYCLES = 4;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_req_type = REQ_LOAD;
  logic [PIXEL_W-1:0]    in_pixel_in = '0;
  logic                  out_ready   = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_SOURCE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic [PIXEL_W-1:0]    out_pixel_out;
  logic [DEST_W-1:0]     out_dest_col;
  logic [DEST_W-1:0]     out_dest_row;
  logic                  out_row_end;
  logic                  out_frame_end;
  int                    results_owed;
  int                    mismatch_total;

  // Stimulus bookkeeping. The top keeps its own count of stored pixels so that it only
  // fetches once every store entry the current geometry can touch has been written.
  int unsigned stored_pixels;
  int unsigned frame_area;
  int          items_sent;
  int          burst_left;
  int          quiet_cycles;
  int          ready_pattern;
  int          pattern_cycles;
  int          stall_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  image_rotate_flip_remap_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_dest_col  (out_dest_col),
    .out_dest_row  (out_dest_row),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  frame_rotation_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_dest_col   (out_dest_col),
    .out_dest_row   (out_dest_row),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .results_owed   (results_owed),
    .mismatch_total (mismatch_total)
  );

  // The receiver switches every so often between three habits: always ready, ready on a
  // coin toss, and mostly ready with occasional stalls.
  always @(posedge clk) begin
    if (pattern_cycles == 0) begin
      ready_pattern  = $urandom_range(0, 2);
      pattern_cycles = $urandom_range(40, 240);
    end else begin
      pattern_cycles--;
    end
    case (ready_pattern)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_cycles > 0) begin
          stall_cycles--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_cycles = $urandom_range(1, 15);
        end
      end
    endcase
  end

  // Watchdog: any cycle without a transfer on either channel counts towards the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Pixels are mostly random, with all-zero and all-one words mixed in.
  function automatic logic [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Presents one item and holds it until the transfer. The sender works in bursts: once a
  // burst is used up it drops valid for a random gap, and some gaps are zero so that long
  // back-to-back stretches occur as well.
  task automatic send_item(input logic req, input logic [PIXEL_W-1:0] pix);
    int gap;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 39);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // A load past the end of the current frame is dropped by the block; it is still sent,
  // but only loads that land in the store count towards the item total.
  task automatic send_load(input logic [PIXEL_W-1:0] pix);
    if (stored_pixels < frame_area) begin
      stored_pixels++;
      items_sent++;
    end
    send_item(REQ_LOAD, pix);
  endtask

  // Loads the rest of the current frame, then a few surplus loads that must be ignored.
  task automatic fill_frame();
    int surplus;
    surplus = $urandom_range(0, 2);
    while (stored_pixels < frame_area) send_load(random_pixel());
    repeat (surplus) send_load(random_pixel());
  endtask

  // Fetches in raster order; with noise on, ignored loads are scattered among them.
  task automatic stream_out(input int count, input bit noisy);
    repeat (count) begin
      if (noisy && $urandom_range(0, 9) == 0) send_load(random_pixel());
      items_sent++;
      send_item(REQ_FETCH, $urandom());
    end
  endtask

  // Stops sending and waits for every outstanding result, then lets the pipeline settle.
  // The first edge is skipped because the count only reflects transfers of earlier edges.
  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Writes all five registers on consecutive edges. Only the low bits of the rotation and
  // mirror registers matter, so their upper bits are filled at random.
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_raw,
                              input logic [CFG_DATA_W-1:0] h_raw,
                              input logic [1:0] turns, input logic flip_h, input logic flip_v);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SOURCE_WIDTH;
    cfg_data  <= w_raw;
    @(posedge clk);
    cfg_index <= REG_SOURCE_HEIGHT;
    cfg_data  <= h_raw;
    @(posedge clk);
    cfg_index <= REG_QUARTER_TURNS;
    cfg_data  <= {(CFG_DATA_W-2)'($urandom()), turns};
    @(posedge clk);
    cfg_index <= REG_MIRROR_HORIZONTAL;
    cfg_data  <= {(CFG_DATA_W-1)'($urandom()), flip_h};
    @(posedge clk);
    cfg_index <= REG_MIRROR_VERTICAL;
    cfg_data  <= {(CFG_DATA_W-1)'($urandom()), flip_v};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [PIXEL_W-1:0]    patterns [6];
    logic [CFG_DATA_W-1:0] w_raw;
    logic [CFG_DATA_W-1:0] h_raw;
    int unsigned           we;
    int unsigned           he;
    int unsigned           cap;
    int unsigned           hmax;
    int unsigned           fetch_max;
    bit                    strip;
    bit                    first_random;

    patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h00FF_00FF, 32'hFF00_FF00};
    stored_pixels = 0;
    items_sent    = 0;
    burst_left    = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A 3 by 2 source is loaded with words that set every bit both ways,
    // two surplus loads follow and must be dropped, and the frame is left part-way through.
    set_geometry(10'd3, 10'd2, TURN_NONE, 1'b0, 1'b0);
    frame_area = 6;
    foreach (patterns[i]) send_load(patterns[i]);
    send_load(random_pixel());
    send_load(random_pixel());
    stream_out(3, 1'b0);
    drain_results(SETTLE_CYCLES);

    // A width of zero acts as one; with a quarter turn the destination becomes 2 by 1, so
    // the saved position falls outside it and fetching has to restart at the origin. The
    // store keeps its 3-wide layout and is now read with the new width.
    set_geometry(10'd0, 10'd2, TURN_90, 1'b1, 1'b1);
    frame_area = 2;
    stream_out(3, 1'b0);
    drain_results(SETTLE_CYCLES);

    // Half and three-quarter turns over the full 3 by 2 frame, one mirror each.
    set_geometry(10'd3, 10'd2, TURN_180, 1'b0, 1'b1);
    frame_area = 6;
    stream_out(5, 1'b0);
    drain_results(SETTLE_CYCLES);
    set_geometry(10'd3, 10'd2, TURN_270, 1'b1, 1'b0);
    stream_out(6, 1'b0);

    // Random part. Each phase waits for all results, picks a new geometry, loads whatever
    // the frame still lacks and then streams fetches with stray loads among them. The load
    // counter never goes back, so frames mostly stay near what is stored; the first phase
    // and about one in six later ones are 512-pixel strips, written above the maximum at
    // times, to reach the largest sizes and coordinates.
    first_random = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      drain_results(SETTLE_CYCLES);
      strip = first_random || ($urandom_range(0, 5) == 0);
      first_random = 1'b0;
      if (strip) begin
        if ($urandom_range(0, 1) == 1) begin
          we = MAX_WIDTH;
          he = 1;
        end else begin
          we = 1;
          he = MAX_HEIGHT;
        end
      end else begin
        cap  = stored_pixels + (($urandom_range(0, 1) == 1) ? $urandom_range(0, 24) : 0);
        we   = $urandom_range(1, (cap < MAX_WIDTH) ? cap : MAX_WIDTH);
        hmax = cap / we;
        he   = $urandom_range(1, (hmax < MAX_HEIGHT) ? hmax : MAX_HEIGHT);
      end
      w_raw = CFG_DATA_W'(we);
      h_raw = CFG_DATA_W'(he);
      if (we == 1 && $urandom_range(0, 1) == 1) w_raw = '0;
      if (he == 1 && $urandom_range(0, 1) == 1) h_raw = '0;
      if (we == MAX_WIDTH) w_raw = CFG_DATA_W'($urandom_range(MAX_WIDTH, 1023));
      if (he == MAX_HEIGHT) h_raw = CFG_DATA_W'($urandom_range(MAX_HEIGHT, 1023));
      set_geometry(w_raw, h_raw, 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      frame_area = we * he;
      fill_frame();
      fetch_max = frame_area + frame_area / 2 + 2;
      if (!strip && fetch_max > 200) fetch_max = 200;
      if (strip && fetch_max > 520) fetch_max = 520;
      stream_out($urandom_range(1, fetch_max), 1'b1);
    end

    drain_results(4 * SETTLE_CYCLES);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rir_pkg.sv
rtl/rir_frame_store.sv
rtl/rir_addr_gen.sv
rtl/image_rotate_flip_remap_unit.sv
tb/frame_rotation_checker.sv
tb/image_rotate_flip_remap_unit_test.sv
